[rtl/abss_pkg.sv]
// ----------------------------------------------------------------------------
// abss_pkg
// Request codes, slot codes and transaction types for the A/B boot-slot
// selector.
// ----------------------------------------------------------------------------
`default_nettype none

package abss_pkg;

	// request codes
	localparam logic [3:0] REQ_BOOT       = 4'd0;
	localparam logic [3:0] REQ_ACTIVE     = 4'd1;
	localparam logic [3:0] REQ_UNBOOTABLE = 4'd2;
	localparam logic [3:0] REQ_SUCCESSFUL = 4'd3;
	localparam logic [3:0] REQ_INFO       = 4'd4;
	localparam logic [3:0] REQ_RECOV      = 4'd5;
	localparam logic [3:0] REQ_BOOTLDR    = 4'd6;
	localparam logic [3:0] REQ_GETCLEAR   = 4'd7;
	localparam logic [3:0] REQ_LASTACTIVE = 4'd8;
	localparam logic [3:0] REQ_LOAD       = 4'd9;

	// slot codes
	localparam logic [1:0] SLOT_A   = 2'd0;
	localparam logic [1:0] SLOT_B   = 2'd1;
	localparam logic [1:0] SLOT_R   = 2'd2;
	localparam logic [1:0] SLOT_BAD = 2'd3;

	// status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// request transaction
	typedef struct packed {
		logic [3:0] req_type;
		logic [1:0] slot_id;
		logic       upd_meta;
		logic       enable;
		logic [7:0] raw_priority;
		logic [7:0] raw_tries;
		logic       raw_successful;
	} req_t;

	// result transaction
	typedef struct packed {
		logic       status;
		logic [1:0] chosen_slot;
		logic       can_boot;
		logic       cur_active;
		logic       is_successful;
		logic [2:0] tries_left;
		logic       recovery_flag;
		logic       bootloader_flag;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/ab_boot_slot_selector_core.sv]
// ----------------------------------------------------------------------------
// ab_boot_slot_selector_core
// Keeps A/B boot-slot metadata and one-shot flags, answers one result per
// request transaction.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  request | in        | req_valid / req_stall  | req (abss_pkg::req_t)
//  result  | out       | rsp_valid / rsp_stall  | rsp (abss_pkg::rsp_t)
//
// One request per cycle while the result is not stalled. Requests go through a
// request register, then decode and slot update logic into the result register.
// Slot state and flags are written when a request moves into the result
// register. Reset sets A to top priority, B one below, full tries, no marks.
// A stalled result holds both stages; the request register still fills when
// it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ab_boot_slot_selector_core #(
	parameter int MAX_PRIORITY = 15,
	parameter int MAX_TRIES    = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire abss_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output abss_pkg::rsp_t     rsp
);

	localparam int PRIO_W  = $clog2(MAX_PRIORITY + 1);
	localparam int TRIES_W = $clog2(MAX_TRIES + 1);
	localparam logic [PRIO_W-1:0]  PRIO_MAX  = PRIO_W'(MAX_PRIORITY);
	localparam logic [TRIES_W-1:0] TRIES_MAX = TRIES_W'(MAX_TRIES);
	localparam logic [7:0] RAW_PRIO_MAX  = 8'(MAX_PRIORITY);
	localparam logic [7:0] RAW_TRIES_MAX = 8'(MAX_TRIES);

	// slot state, index 0 is A, 1 is B
	logic [PRIO_W-1:0]  prio_q  [2];
	logic [TRIES_W-1:0] tries_q [2];
	logic               succ_q  [2];
	logic               recov_q;
	logic               bootldr_q;

	logic [PRIO_W-1:0]  prio_n  [2];
	logic [TRIES_W-1:0] tries_n [2];
	logic               succ_n  [2];
	logic               recov_n;
	logic               bootldr_n;

	logic               valid_s1;
	abss_pkg::req_t     req_s1;
	abss_pkg::rsp_t     rsp_n;
	logic               advance;

	// pipeline control
	assign advance   = !rsp_valid || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// bootability and active slot
	logic       boot_a, boot_b;
	logic [PRIO_W-1:0] pa, pb;
	logic [1:0] act;

	always_comb begin
		boot_a = (prio_q[0] != '0) && (succ_q[0] || (tries_q[0] != '0));
		boot_b = (prio_q[1] != '0) && (succ_q[1] || (tries_q[1] != '0));
		pa = boot_a ? prio_q[0] : '0;
		pb = boot_b ? prio_q[1] : '0;
		if (pb > pa) begin
			act = abss_pkg::SLOT_B;
		end else if (pa != '0) begin
			act = abss_pkg::SLOT_A;
		end else begin
			act = abss_pkg::SLOT_R;
		end
	end

	// request decode and slot update
	logic       ab;
	logic       sel;
	logic       sel_boot;
	logic       oth_boot;
	logic [7:0] rp_c;
	logic [7:0] rt_c;
	logic [7:0] t8;

	always_comb begin
		ab       = !req_s1.slot_id[1];
		sel      = req_s1.slot_id[0];
		sel_boot = sel ? boot_b : boot_a;
		oth_boot = sel ? boot_a : boot_b;
		rp_c = (req_s1.raw_priority > RAW_PRIO_MAX) ? RAW_PRIO_MAX : req_s1.raw_priority;
		rt_c = (req_s1.raw_tries > RAW_TRIES_MAX) ? RAW_TRIES_MAX : req_s1.raw_tries;
		t8   = 8'(sel ? tries_q[1] : tries_q[0]);

		for (int k = 0; k < 2; k++) begin
			prio_n[k]  = prio_q[k];
			tries_n[k] = tries_q[k];
			succ_n[k]  = succ_q[k];
		end
		recov_n   = recov_q;
		bootldr_n = bootldr_q;
		rsp_n     = '0;

		case (req_s1.req_type)
			abss_pkg::REQ_BOOT: begin
				if (recov_q && req_s1.upd_meta) begin
					recov_n = 1'b0;
					rsp_n.chosen_slot = abss_pkg::SLOT_R;
				end else begin
					rsp_n.chosen_slot = act;
					rsp_n.is_successful = (act != abss_pkg::SLOT_R) && succ_q[act[0]];
					if (req_s1.upd_meta) begin
						for (int k = 0; k < 2; k++) begin
							if (act == 2'(k)) begin
								if (!succ_q[k] && (tries_q[k] != '0)) begin
									tries_n[k] = tries_q[k] - TRIES_W'(1);
								end
							end else if (succ_q[k]) begin
								tries_n[k] = TRIES_MAX;
								succ_n[k]  = 1'b0;
							end
						end
					end
				end
			end
			abss_pkg::REQ_ACTIVE: begin
				if (!ab) begin
					rsp_n.status = abss_pkg::STATUS_ERR;
				end else begin
					for (int k = 0; k < 2; k++) begin
						if (sel == 1'(k)) begin
							prio_n[k]  = PRIO_MAX;
							tries_n[k] = TRIES_MAX;
							succ_n[k]  = 1'b0;
						end else if (prio_q[k] == PRIO_MAX) begin
							prio_n[k] = prio_q[k] - PRIO_W'(1);
						end
					end
				end
			end
			abss_pkg::REQ_UNBOOTABLE: begin
				if (!ab) begin
					rsp_n.status = abss_pkg::STATUS_ERR;
				end else begin
					for (int k = 0; k < 2; k++) begin
						if (sel == 1'(k)) begin
							tries_n[k] = '0;
							succ_n[k]  = 1'b0;
						end
					end
				end
			end
			abss_pkg::REQ_SUCCESSFUL: begin
				if (!ab || !sel_boot) begin
					rsp_n.status = abss_pkg::STATUS_ERR;
				end else begin
					for (int k = 0; k < 2; k++) begin
						if (sel == 1'(k)) begin
							tries_n[k] = '0;
							succ_n[k]  = 1'b1;
						end else if (oth_boot) begin
							tries_n[k] = TRIES_MAX;
							succ_n[k]  = 1'b0;
						end
					end
				end
			end
			abss_pkg::REQ_INFO: begin
				if (req_s1.slot_id == abss_pkg::SLOT_BAD) begin
					rsp_n.status = abss_pkg::STATUS_ERR;
				end else if (req_s1.slot_id == abss_pkg::SLOT_R) begin
					rsp_n.can_boot      = 1'b1;
					rsp_n.cur_active    = (act == abss_pkg::SLOT_R);
					rsp_n.is_successful = 1'b1;
				end else begin
					rsp_n.can_boot      = sel_boot;
					rsp_n.cur_active    = (act == {1'b0, sel});
					rsp_n.is_successful = sel ? succ_q[1] : succ_q[0];
					rsp_n.tries_left    = t8[2:0];
				end
			end
			abss_pkg::REQ_RECOV: begin
				recov_n = req_s1.enable;
			end
			abss_pkg::REQ_BOOTLDR: begin
				bootldr_n = req_s1.enable;
			end
			abss_pkg::REQ_GETCLEAR: begin
				rsp_n.recovery_flag   = recov_q;
				rsp_n.bootloader_flag = bootldr_q;
				recov_n   = 1'b0;
				bootldr_n = 1'b0;
			end
			abss_pkg::REQ_LASTACTIVE: begin
				rsp_n.chosen_slot = (prio_q[1] > prio_q[0]) ? abss_pkg::SLOT_B : abss_pkg::SLOT_A;
			end
			abss_pkg::REQ_LOAD: begin
				if (!ab) begin
					rsp_n.status = abss_pkg::STATUS_ERR;
				end else begin
					for (int k = 0; k < 2; k++) begin
						if (sel == 1'(k)) begin
							prio_n[k] = PRIO_W'(rp_c);
							if (req_s1.raw_priority == 8'd0) begin
								tries_n[k] = '0;
								succ_n[k]  = 1'b0;
							end else if ((req_s1.raw_tries != 8'd0) && req_s1.raw_successful) begin
								tries_n[k] = TRIES_MAX;
								succ_n[k]  = 1'b0;
							end else begin
								tries_n[k] = TRIES_W'(rt_c);
								succ_n[k]  = req_s1.raw_successful;
							end
						end
					end
				end
			end
			default: begin
				rsp_n.status = abss_pkg::STATUS_ERR;
			end
		endcase
	end

	// slot state, written as a request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q[0]  <= PRIO_MAX;
			prio_q[1]  <= PRIO_MAX - PRIO_W'(1);
			tries_q[0] <= TRIES_MAX;
			tries_q[1] <= TRIES_MAX;
			succ_q[0]  <= 1'b0;
			succ_q[1]  <= 1'b0;
			recov_q    <= 1'b0;
			bootldr_q  <= 1'b0;
		end else if (advance && valid_s1) begin
			for (int k = 0; k < 2; k++) begin
				prio_q[k]  <= prio_n[k];
				tries_q[k] <= tries_n[k];
				succ_q[k]  <= succ_n[k];
			end
			recov_q   <= recov_n;
			bootldr_q <= bootldr_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp <= rsp_n;
		end
	end

endmodule

`default_nettype wire

[bench/tb_ab_boot_slot_selector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ab_boot_slot_selector_core
// Self-checking bench for the A/B boot-slot selector. A queue of request
// transactions (a directed opening, then weighted random traffic) feeds a
// clocked driver. A behavioral model of the slot metadata predicts each
// result at acceptance. A clocked monitor stalls the result channel at random
// and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_ab_boot_slot_selector_core;

	localparam int MAX_PRI = 15;
	localparam int MAX_TRY = 7;
	localparam int RANDOM_ITEMS = 750;
	localparam int LONG_HOLD_AT = 400;
	localparam int LONG_HOLD_CYCLES = 80;

	// one queued request plus its pacing
	typedef struct {
		abss_pkg::req_t pkt;
		int   gap;
		bit   drain;
	} pending_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   req_valid = 1'b0;
	logic   req_stall;
	abss_pkg::req_t req = '0;
	logic   rsp_valid;
	logic   rsp_stall = 1'b0;
	abss_pkg::rsp_t rsp;

	pending_t pending_reqs[$];
	abss_pkg::rsp_t expected_rsps[$];
	pending_t next_req;
	int       gap_left;
	int       mismatches = 0;
	int       rsp_seen = 0;
	int       stall_left;
	int       run_left;
	bit       long_hold_done;
	bit       next_stall;
	int       pick;

	// predicted slot metadata
	logic [3:0] slot_pri [2];
	logic [2:0] slot_try [2];
	logic       slot_ok [2];
	logic       flag_recovery;
	logic       flag_bootloader;

	ab_boot_slot_selector_core #(
		.MAX_PRIORITY(MAX_PRI),
		.MAX_TRIES(MAX_TRY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Slot metadata model
	// ------------------------------------------------------------------

	// clamp and clean up one slot's values
	function automatic void settle(inout logic [7:0] p, inout logic [7:0] t, inout logic sc);
		if (p == 8'd0) begin
			t = 8'd0;
			sc = 1'b0;
		end else begin
			if (t != 8'd0 && sc) begin
				t = 8'(MAX_TRY);
				sc = 1'b0;
			end
			if (p > 8'(MAX_PRI))
				p = 8'(MAX_PRI);
			if (t > 8'(MAX_TRY))
				t = 8'(MAX_TRY);
		end
	endfunction

	function automatic bit slot_bootable(int k);
		return slot_pri[k] != 4'd0 && (slot_ok[k] || slot_try[k] != 3'd0);
	endfunction

	// higher bootable priority wins, A on a tie, R when none
	function automatic logic [1:0] active_slot();
		logic [3:0] pa;
		logic [3:0] pb;
		pa = slot_bootable(0) ? slot_pri[0] : 4'd0;
		pb = slot_bootable(1) ? slot_pri[1] : 4'd0;
		if (pb > pa)
			return abss_pkg::SLOT_B;
		if (pa != 4'd0)
			return abss_pkg::SLOT_A;
		return abss_pkg::SLOT_R;
	endfunction

	function automatic void reset_slots();
		slot_pri[0] = 4'(MAX_PRI);
		slot_pri[1] = 4'(MAX_PRI - 1);
		slot_try[0] = 3'(MAX_TRY);
		slot_try[1] = 3'(MAX_TRY);
		slot_ok[0] = 1'b0;
		slot_ok[1] = 1'b0;
		flag_recovery = 1'b0;
		flag_bootloader = 1'b0;
	endfunction

	// apply one request to the model and return its result
	function automatic abss_pkg::rsp_t predict_rsp(abss_pkg::req_t q);
		abss_pkg::rsp_t o;
		logic [7:0] p;
		logic [7:0] t;
		logic       sc;
		logic [1:0] b;
		int         s;
		int         other;
		bit         ab;
		o = '0;
		s = int'(q.slot_id[0]);
		other = 1 - s;
		ab = !q.slot_id[1];
		for (int k = 0; k < 2; k++) begin
			p = {4'd0, slot_pri[k]};
			t = {5'd0, slot_try[k]};
			sc = slot_ok[k];
			settle(p, t, sc);
			slot_pri[k] = p[3:0];
			slot_try[k] = t[2:0];
			slot_ok[k] = sc;
		end
		case (q.req_type)
			abss_pkg::REQ_BOOT: begin
				if (flag_recovery && q.upd_meta) begin
					flag_recovery = 1'b0;
					o.chosen_slot = abss_pkg::SLOT_R;
				end else begin
					b = active_slot();
					o.chosen_slot = b;
					if (b != abss_pkg::SLOT_R && slot_ok[b[0]])
						o.is_successful = 1'b1;
					if (q.upd_meta) begin
						if (b != abss_pkg::SLOT_R && !slot_ok[b[0]] && slot_try[b[0]] != 3'd0)
							slot_try[b[0]] = slot_try[b[0]] - 3'd1;
						// stale success marks on the other slots go away
						for (int k = 0; k < 2; k++) begin
							if (!(b != abss_pkg::SLOT_R && k == b[0]) && slot_ok[k]) begin
								slot_try[k] = 3'(MAX_TRY);
								slot_ok[k] = 1'b0;
							end
						end
					end
				end
			end
			abss_pkg::REQ_ACTIVE: begin
				if (!ab) begin
					o.status = abss_pkg::STATUS_ERR;
				end else begin
					slot_pri[s] = 4'(MAX_PRI);
					slot_try[s] = 3'(MAX_TRY);
					slot_ok[s] = 1'b0;
					if (slot_pri[other] == 4'(MAX_PRI))
						slot_pri[other] = slot_pri[other] - 4'd1;
				end
			end
			abss_pkg::REQ_UNBOOTABLE: begin
				if (!ab) begin
					o.status = abss_pkg::STATUS_ERR;
				end else begin
					slot_try[s] = 3'd0;
					slot_ok[s] = 1'b0;
				end
			end
			abss_pkg::REQ_SUCCESSFUL: begin
				if (!ab || !slot_bootable(s)) begin
					o.status = abss_pkg::STATUS_ERR;
				end else begin
					slot_try[s] = 3'd0;
					slot_ok[s] = 1'b1;
					if (slot_bootable(other)) begin
						slot_try[other] = 3'(MAX_TRY);
						slot_ok[other] = 1'b0;
					end
				end
			end
			abss_pkg::REQ_INFO: begin
				if (q.slot_id == abss_pkg::SLOT_BAD) begin
					o.status = abss_pkg::STATUS_ERR;
				end else if (q.slot_id == abss_pkg::SLOT_R) begin
					o.can_boot = 1'b1;
					o.cur_active = active_slot() == abss_pkg::SLOT_R;
					o.is_successful = 1'b1;
				end else begin
					o.can_boot = slot_bootable(s);
					o.cur_active = active_slot() == q.slot_id;
					o.is_successful = slot_ok[s];
					o.tries_left = slot_try[s];
				end
			end
			abss_pkg::REQ_RECOV:
				flag_recovery = q.enable;
			abss_pkg::REQ_BOOTLDR:
				flag_bootloader = q.enable;
			abss_pkg::REQ_GETCLEAR: begin
				o.recovery_flag = flag_recovery;
				o.bootloader_flag = flag_bootloader;
				flag_recovery = 1'b0;
				flag_bootloader = 1'b0;
			end
			abss_pkg::REQ_LASTACTIVE:
				o.chosen_slot = slot_pri[1] > slot_pri[0] ? abss_pkg::SLOT_B : abss_pkg::SLOT_A;
			abss_pkg::REQ_LOAD: begin
				if (!ab) begin
					o.status = abss_pkg::STATUS_ERR;
				end else begin
					p = q.raw_priority;
					t = q.raw_tries;
					sc = q.raw_successful;
					settle(p, t, sc);
					slot_pri[s] = p[3:0];
					slot_try[s] = t[2:0];
					slot_ok[s] = sc;
				end
			end
			default:
				o.status = abss_pkg::STATUS_ERR;
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic abss_pkg::req_t mk_req(logic [3:0] kind, logic [1:0] slot, logic upd,
			logic en, logic [7:0] rp, logic [7:0] rt, logic rs);
		abss_pkg::req_t q;
		q.req_type = kind;
		q.slot_id = slot;
		q.upd_meta = upd;
		q.enable = en;
		q.raw_priority = rp;
		q.raw_tries = rt;
		q.raw_successful = rs;
		return q;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// weighted mix of requests with random content, a few with unused request codes
	function automatic abss_pkg::req_t rand_request();
		abss_pkg::req_t q;
		logic [31:0] bits;
		int          r;
		bits = $urandom();
		q = bits[$bits(abss_pkg::req_t)-1:0];
		r = $urandom_range(0, 99);
		if (r < 25)      q.req_type = abss_pkg::REQ_BOOT;
		else if (r < 33) q.req_type = abss_pkg::REQ_ACTIVE;
		else if (r < 40) q.req_type = abss_pkg::REQ_UNBOOTABLE;
		else if (r < 50) q.req_type = abss_pkg::REQ_SUCCESSFUL;
		else if (r < 63) q.req_type = abss_pkg::REQ_INFO;
		else if (r < 68) q.req_type = abss_pkg::REQ_RECOV;
		else if (r < 73) q.req_type = abss_pkg::REQ_BOOTLDR;
		else if (r < 78) q.req_type = abss_pkg::REQ_GETCLEAR;
		else if (r < 83) q.req_type = abss_pkg::REQ_LASTACTIVE;
		else if (r < 95) q.req_type = abss_pkg::REQ_LOAD;
		else             q.req_type = 4'($urandom_range(10, 15));
		r = $urandom_range(0, 9);
		q.slot_id = r < 4 ? abss_pkg::SLOT_A : r < 8 ? abss_pkg::SLOT_B :
			r < 9 ? abss_pkg::SLOT_R : abss_pkg::SLOT_BAD;
		// small raw values hit the normalization corners more often
		if (q.req_type == abss_pkg::REQ_LOAD && $urandom_range(0, 1) == 1) begin
			q.raw_priority = 8'($urandom_range(0, 17));
			q.raw_tries = 8'($urandom_range(0, 9));
		end
		return q;
	endfunction

	// pacing depends on position: a calm burst and a burst for the long hold
	task automatic add_req(abss_pkg::req_t q);
		pending_t e;
		int       n;
		n = pending_reqs.size();
		e.pkt = q;
		e.drain = (n == 25 || n == 600);
		if ((n >= 100 && n < 200) || (n >= 380 && n < 470))
			e.gap = 0;
		else
			e.gap = pick_gap();
		pending_reqs.push_back(e);
	endtask

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(predict_rsp(req));
			if (req_valid && req_stall) begin
				// stalled: payload holds
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
				next_req = pending_reqs.pop_front();
				req <= next_req.pkt;
				req_valid <= 1'b1;
				gap_left <= next_req.gap;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and stall generator
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			run_left = 0;
			long_hold_done = 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with nothing expected: %h", rsp_seen, rsp);
				end else begin
					if (rsp.status !== expected_rsps[0].status ||
							rsp.chosen_slot !== expected_rsps[0].chosen_slot ||
							rsp.can_boot !== expected_rsps[0].can_boot ||
							rsp.cur_active !== expected_rsps[0].cur_active ||
							rsp.is_successful !== expected_rsps[0].is_successful ||
							rsp.tries_left !== expected_rsps[0].tries_left ||
							rsp.recovery_flag !== expected_rsps[0].recovery_flag ||
							rsp.bootloader_flag !== expected_rsps[0].bootloader_flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result %0d mismatch (st ch ib ia is tl rf bf): ",
								"expected %0d %0d %0d %0d %0d %0d %0d %0d, ",
								"got %0d %0d %0d %0d %0d %0d %0d %0d"}, rsp_seen,
								expected_rsps[0].status, expected_rsps[0].chosen_slot,
								expected_rsps[0].can_boot, expected_rsps[0].cur_active,
								expected_rsps[0].is_successful, expected_rsps[0].tries_left,
								expected_rsps[0].recovery_flag,
								expected_rsps[0].bootloader_flag,
								rsp.status, rsp.chosen_slot, rsp.can_boot, rsp.cur_active,
								rsp.is_successful, rsp.tries_left, rsp.recovery_flag,
								rsp.bootloader_flag);
					end
					void'(expected_rsps.pop_front());
				end
				rsp_seen++;
			end

			// one long hold while the sender keeps pushing
			if (!long_hold_done && rsp_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end

			if (rsp_seen >= 100 && rsp_seen < 200 && stall_left == 0) begin
				next_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				next_stall = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					run_left = $urandom_range(0, 6);
					next_stall = 1'b0;
				end else if (pick < 93) begin
					stall_left = $urandom_range(0, 2);
					next_stall = 1'b1;
				end else begin
					stall_left = $urandom_range(8, 30);
					next_stall = 1'b1;
				end
			end
			rsp_stall <= next_stall;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		reset_slots();

		// directed opening
		add_req(mk_req(abss_pkg::REQ_INFO, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_INFO, abss_pkg::SLOT_B, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_INFO, abss_pkg::SLOT_R, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_INFO, abss_pkg::SLOT_BAD, 1'b1, 1'b1, 8'hff, 8'hff, 1'b1));
		add_req(mk_req(abss_pkg::REQ_BOOT, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_BOOT, abss_pkg::SLOT_A, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_SUCCESSFUL, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_BOOT, abss_pkg::SLOT_A, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_ACTIVE, abss_pkg::SLOT_B, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_LASTACTIVE, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_BOOT, abss_pkg::SLOT_A, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_UNBOOTABLE, abss_pkg::SLOT_B, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_UNBOOTABLE, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		// nothing bootable: recovery is active
		add_req(mk_req(abss_pkg::REQ_INFO, abss_pkg::SLOT_R, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_BOOT, abss_pkg::SLOT_A, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_SUCCESSFUL, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_RECOV, abss_pkg::SLOT_A, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_BOOTLDR, abss_pkg::SLOT_A, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_BOOT, abss_pkg::SLOT_A, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0));
		add_req(mk_req(abss_pkg::REQ_GETCLEAR, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
		// raw loads at the extremes, then on the wrong slot, then unused request codes
		add_req(mk_req(abss_pkg::REQ_LOAD, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'hff, 8'hff, 1'b1));
		add_req(mk_req(abss_pkg::REQ_LOAD, abss_pkg::SLOT_B, 1'b0, 1'b0, 8'h00, 8'hff, 1'b1));
		add_req(mk_req(abss_pkg::REQ_LOAD, abss_pkg::SLOT_R, 1'b0, 1'b0, 8'h05, 8'h03, 1'b0));
		add_req(mk_req(4'hf, abss_pkg::SLOT_BAD, 1'b1, 1'b1, 8'hff, 8'hff, 1'b1));
		add_req(mk_req(4'ha, abss_pkg::SLOT_A, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));

		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_req(rand_request());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
